### rtl/srs_pkg.sv
// ============================================================================
// srs_pkg
// Shared constants and types of the sorted range search block.
// ============================================================================
package srs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_BITS  = 32;
    localparam int POS_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int CMD_BITS    = 3;

    localparam int CMD_LSB     = 0;
    localparam int LPOS_LSB    = CMD_LSB + CMD_BITS;
    localparam int LVAL_LSB    = LPOS_LSB + POS_BITS;
    localparam int LO_LSB      = LVAL_LSB + VALUE_BITS;
    localparam int HI_LSB      = LO_LSB + POS_BITS;
    localparam int KEY_LSB     = HI_LSB + POS_BITS;
    localparam int IN_BITS     = KEY_LSB + VALUE_BITS;
    localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS      = 1 + POS_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD     = 3'd0,
        CMD_FIRST_EQ = 3'd1,
        CMD_LAST_EQ  = 3'd2,
        CMD_LOWER    = 3'd3,
        CMD_UPPER    = 3'd4
    } t_cmd;

endpackage

### rtl/srs_ram.sv
// ============================================================================
// srs_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module srs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sorted_range_search.sv
// ============================================================================
// sorted_range_search
// Binary search over a table of signed values held in one synchronous RAM.
// ============================================================================
// The slave stream carries one command per transaction. A load writes one
// table entry and leaves the input ready; it produces no output transaction.
// A query searches positions range_lo..range_hi of the table, which is
// assumed sorted nondecreasing, and produces one output transaction with
// found and position. Commands 5 to 7 are dropped without a result.
// A query passes a start state, which for the first-greater query reads
// range_hi to check it first, then the probes of the binary search with
// one RAM read each (over the full table up to 10 for the equality
// queries and up to 11 for the bound queries), for the equality queries
// one more read for the final check, and a result state that moves the
// answer to the output register. The RAM read port allows one probe per
// cycle. A query with an empty or out-of-range window goes from accept
// to the result state, which loads its answer into the output register
// and frees the input in the same cycle.
// The answer waits in an output register, so a stalled receiver does not
// stop loads or the start of the next query; only a second answer waits
// until the first is taken. Reset clears the control state and the output
// valid flag; table contents are undefined until loaded.
// ============================================================================
module sorted_range_search
    import srs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // cmd, load_pos, load_value, range_lo, range_hi, search_key, zero pad
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // found, position, zero pad
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_PRE,
        ST_SEARCH,
        ST_CHECK,
        ST_RESULT
    } t_state;

    t_state                       r_state;
    t_cmd                         r_cmd;
    logic [POS_BITS-1:0]          r_a;
    logic [POS_BITS-1:0]          r_b;
    logic [POS_BITS-1:0]          r_hi;
    logic signed [VALUE_BITS-1:0] r_key;
    logic                         r_res_found;
    logic [POS_BITS-1:0]          r_res_pos;
    logic                         r_out_valid;
    logic                         r_out_found;
    logic [POS_BITS-1:0]          r_out_pos;

    t_cmd                         w_cmd;
    logic [POS_BITS-1:0]          w_load_pos;
    logic [VALUE_BITS-1:0]        w_load_value;
    logic [POS_BITS-1:0]          w_lo;
    logic [POS_BITS-1:0]          w_hi;
    logic [VALUE_BITS-1:0]        w_key;
    logic                         w_accept;
    logic                         w_is_query;
    logic                         w_bad_range;

    logic                         ram_we;
    logic [ADDR_BITS-1:0]         ram_waddr;
    logic [ADDR_BITS-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0]        ram_rdata;

    logic signed [VALUE_BITS-1:0] w_rd;
    logic                         w_lt;
    logic                         w_gt;
    logic [POS_BITS-1:0]          w_probe;
    logic [POS_BITS-1:0]          w_step;
    logic                         w_go_right;
    logic [POS_BITS-1:0]          n_a;
    logic [POS_BITS-1:0]          n_b;
    logic                         w_more_next;

    function automatic logic f_is_eq(input t_cmd cmd);
        return (cmd == CMD_FIRST_EQ) || (cmd == CMD_LAST_EQ);
    endfunction

    function automatic logic [POS_BITS-1:0] f_probe(input t_cmd cmd,
                                                    input logic [POS_BITS-1:0] a,
                                                    input logic [POS_BITS-1:0] b);
        logic [POS_BITS:0] sum;
        logic [POS_BITS-1:0] res;
        case (cmd)
            CMD_FIRST_EQ: begin
                sum = {1'b0, a} + {1'b0, b};
                res = sum[POS_BITS:1];
            end
            CMD_LAST_EQ: begin
                sum = {1'b0, a} + {1'b0, b} + (POS_BITS + 1)'(1);
                res = sum[POS_BITS:1];
            end
            default: begin
                sum = {1'b0, a} + {2'b00, b[POS_BITS-1:1]};
                res = sum[POS_BITS-1:0];
            end
        endcase
        return res;
    endfunction

    function automatic logic f_more(input t_cmd cmd,
                                    input logic [POS_BITS-1:0] a,
                                    input logic [POS_BITS-1:0] b);
        return f_is_eq(cmd) ? (a < b) : (b != '0);
    endfunction

    function automatic logic [ADDR_BITS-1:0] f_addr(input logic [POS_BITS-1:0] pos);
        logic [POS_BITS-1:0] idx;
        idx = pos - POS_BITS'(1);
        return idx[ADDR_BITS-1:0];
    endfunction

    assign w_cmd        = t_cmd'(s_axis_tdata[CMD_LSB +: CMD_BITS]);
    assign w_load_pos   = s_axis_tdata[LPOS_LSB +: POS_BITS];
    assign w_load_value = s_axis_tdata[LVAL_LSB +: VALUE_BITS];
    assign w_lo         = s_axis_tdata[LO_LSB +: POS_BITS];
    assign w_hi         = s_axis_tdata[HI_LSB +: POS_BITS];
    assign w_key        = s_axis_tdata[KEY_LSB +: VALUE_BITS];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_is_query    = (w_cmd == CMD_FIRST_EQ) || (w_cmd == CMD_LAST_EQ) ||
                           (w_cmd == CMD_LOWER) || (w_cmd == CMD_UPPER);
    assign w_bad_range   = (w_lo == '0) || (w_hi > POS_BITS'(TABLE_DEPTH)) || (w_lo > w_hi);

    assign ram_we    = w_accept && (w_cmd == CMD_LOAD) && (w_load_pos != '0) &&
                       (w_load_pos <= POS_BITS'(TABLE_DEPTH));
    assign ram_waddr = f_addr(w_load_pos);

    srs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (w_load_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_rd    = $signed(ram_rdata);
    assign w_lt    = w_rd < r_key;
    assign w_gt    = w_rd > r_key;
    assign w_probe = f_probe(r_cmd, r_a, r_b);
    assign w_step  = {1'b0, r_b[POS_BITS-1:1]};

    always_comb begin
        n_a        = r_a;
        n_b        = r_b;
        w_go_right = 1'b0;
        case (r_cmd)
            CMD_FIRST_EQ: begin
                if (w_lt) begin
                    n_a = w_probe + POS_BITS'(1);
                end else begin
                    n_b = w_probe;
                end
            end
            CMD_LAST_EQ: begin
                if (w_gt) begin
                    n_b = w_probe - POS_BITS'(1);
                end else begin
                    n_a = w_probe;
                end
            end
            default: begin
                w_go_right = (r_cmd == CMD_LOWER) ? w_lt : !w_gt;
                if (w_go_right) begin
                    n_a = w_probe + POS_BITS'(1);
                    n_b = r_b - w_step - POS_BITS'(1);
                end else begin
                    n_b = w_step;
                end
            end
        endcase
        w_more_next = f_more(r_cmd, n_a, n_b);
    end

    always_comb begin
        case (r_state)
            ST_START: begin
                if (r_cmd == CMD_UPPER) begin
                    ram_raddr = f_addr(r_hi);
                end else if (f_more(r_cmd, r_a, r_b)) begin
                    ram_raddr = f_addr(w_probe);
                end else begin
                    ram_raddr = f_addr(r_a);
                end
            end
            ST_PRE: begin
                ram_raddr = f_addr(w_probe);
            end
            ST_SEARCH: begin
                ram_raddr = w_more_next ? f_addr(f_probe(r_cmd, n_a, n_b)) : f_addr(n_a);
            end
            default: begin
                ram_raddr = f_addr(r_a);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_RESULT && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && w_is_query) begin
                        r_cmd <= w_cmd;
                        r_a   <= w_lo;
                        r_hi  <= w_hi;
                        r_key <= $signed(w_key);
                        r_b   <= f_is_eq(w_cmd) ? w_hi : (w_hi - w_lo + POS_BITS'(1));
                        if (w_bad_range) begin
                            r_res_found <= 1'b0;
                            r_res_pos   <= '0;
                            r_state     <= ST_RESULT;
                        end else begin
                            r_state <= ST_START;
                        end
                    end
                end
                ST_START: begin
                    if (r_cmd == CMD_UPPER) begin
                        r_state <= ST_PRE;
                    end else if (f_more(r_cmd, r_a, r_b)) begin
                        r_state <= ST_SEARCH;
                    end else begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_PRE: begin
                    if (w_gt) begin
                        r_state <= ST_SEARCH;
                    end else begin
                        r_res_found <= 1'b0;
                        r_res_pos   <= '0;
                        r_state     <= ST_RESULT;
                    end
                end
                ST_SEARCH: begin
                    r_a <= n_a;
                    r_b <= n_b;
                    if (!w_more_next) begin
                        if (f_is_eq(r_cmd)) begin
                            r_state <= ST_CHECK;
                        end else begin
                            r_res_found <= (n_a <= r_hi);
                            r_res_pos   <= (n_a <= r_hi) ? n_a : '0;
                            r_state     <= ST_RESULT;
                        end
                    end
                end
                ST_CHECK: begin
                    r_res_found <= (w_rd == r_key);
                    r_res_pos   <= (w_rd == r_key) ? r_a : '0;
                    r_state     <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_found <= r_res_found;
                        r_out_pos   <= r_res_pos;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_BITS'({r_out_pos, r_out_found});

endmodule

### rtl/srs_chk.sv
// ============================================================================
// srs_chk
// Port-level checks of the sorted range search block, bound to the top level.
// ============================================================================
module srs_chk
    import srs_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

    logic [CMD_BITS-1:0] w_cmd;
    assign w_cmd = s_axis_tdata[CMD_LSB +: CMD_BITS];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Output transaction changed while stalled.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output valid after reset.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[POS_BITS:1] == '0)
        else $error("Not-found result carries a nonzero position.");

    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            m_axis_tdata[POS_BITS:1] != '0 &&
            m_axis_tdata[POS_BITS:1] <= POS_BITS'(TABLE_DEPTH))
        else $error("Found result carries a position outside the table.");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready &&
        (w_cmd == CMD_FIRST_EQ || w_cmd == CMD_LAST_EQ ||
         w_cmd == CMD_LOWER || w_cmd == CMD_UPPER) |=> !s_axis_tready)
        else $error("Input ready right after a query transaction.");

endmodule

bind sorted_range_search srs_chk u_srs_chk (.*);

### bench/sorted_range_search_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// sorted_range_search_tb
// Self-checking bench for the sorted range search block.
// ============================================================================
// Loads sorted and unsorted runs of entries, queries windows over loaded
// entries and sends bad loads, commands 5 to 7 and bad windows. Each query
// answer is compared with a behavioral search that keeps its own copy of
// the table. Both stream sides idle at random, in stretches and in bursts.
// ============================================================================
module sorted_range_search_tb;
    import srs_pkg::*;

    localparam int ITEM_TARGET  = 1900;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 32;
    localparam int CMD_CODES    = 1 << CMD_BITS;
    localparam int POS_MAX_CODE = (1 << POS_BITS) - 1;
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    typedef struct {
        logic [CMD_BITS-1:0]          cmd;
        logic [POS_BITS-1:0]          load_pos;
        logic signed [VALUE_BITS-1:0] load_value;
        logic [POS_BITS-1:0]          range_lo;
        logic [POS_BITS-1:0]          range_hi;
        logic signed [VALUE_BITS-1:0] search_key;
    } t_search_cmd;

    typedef struct {
        logic                found;
        logic [POS_BITS-1:0] position;
    } t_search_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // cmd, load_pos, load_value, range_lo, range_hi, search_key, zero pad
    logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // found, position, zero pad
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    t_search_cmd    pending_cmds[$];
    t_search_answer answers_due[$];

    logic signed [VALUE_BITS-1:0] table_copy [1:TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0] plan_value [1:TABLE_DEPTH];
    bit                           plan_loaded [1:TABLE_DEPTH];

    t_search_cmd              in_flight;
    t_search_answer           got, want;
    logic [IN_TDATA_BITS-1:0] tx_word;
    int  send_gap = 0;
    int  recv_stall = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;
    int  n_planned = 0;
    int  n_total = 0;
    int  n_accepted = 0;
    int  n_loads = 0;
    int  n_dropped = 0;
    int  n_query[CMD_CODES];
    int  n_results = 0;
    int  n_hits = 0;
    int  n_errors = 0;
    int  cycle_count = 0;

    sorted_range_search i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Lower/upper bound by halving the candidate count.
    function automatic int bound_search(int lo, int hi, logic signed [VALUE_BITS-1:0] key,
                                        bit inclusive);
        int   first;
        int   count;
        int   step;
        int   p;
        logic go_right;
        first = lo;
        count = hi - lo + 1;
        while (count > 0) begin
            step = count / 2;
            p = first + step;
            go_right = inclusive ? (table_copy[p] <= key) : (table_copy[p] < key);
            if (go_right) begin
                first = p + 1;
                count -= step + 1;
            end else begin
                count = step;
            end
        end
        return first;
    endfunction

    task automatic track_transaction(t_search_cmd t);
        t_search_answer r;
        int lo;
        int hi;
        int a;
        int b;
        int mid;
        int p;
        lo = t.range_lo;
        hi = t.range_hi;
        p = 0;
        case (t.cmd)
            CMD_LOAD: begin
                if (t.load_pos >= 1 && t.load_pos <= TABLE_DEPTH) begin
                    table_copy[t.load_pos] = t.load_value;
                    n_loads++;
                end else begin
                    n_dropped++;
                end
            end
            CMD_FIRST_EQ, CMD_LAST_EQ, CMD_LOWER, CMD_UPPER: begin
                n_query[t.cmd]++;
                if (lo >= 1 && hi <= TABLE_DEPTH && lo <= hi) begin
                    a = lo;
                    b = hi;
                    if (t.cmd == CMD_FIRST_EQ) begin
                        while (a < b) begin
                            mid = (a + b) / 2;
                            if (table_copy[mid] >= t.search_key) b = mid;
                            else a = mid + 1;
                        end
                        if (table_copy[a] == t.search_key) p = a;
                    end else if (t.cmd == CMD_LAST_EQ) begin
                        while (a < b) begin
                            mid = (a + b + 1) / 2;
                            if (table_copy[mid] <= t.search_key) a = mid;
                            else b = mid - 1;
                        end
                        if (table_copy[a] == t.search_key) p = a;
                    end else if (t.cmd == CMD_LOWER) begin
                        p = bound_search(lo, hi, t.search_key, 1'b0);
                        if (p > hi) p = 0;
                    end else if (table_copy[hi] > t.search_key) begin
                        p = bound_search(lo, hi, t.search_key, 1'b1);
                        if (p > hi) p = 0;
                    end
                end
                r.found = (p != 0);
                r.position = POS_BITS'(p);
                answers_due.push_back(r);
            end
            default: n_dropped++;
        endcase
    endtask

    function automatic t_search_cmd random_cmd();
        t_search_cmd t;
        t.cmd        = CMD_BITS'($urandom_range(0, CMD_CODES - 1));
        t.load_pos   = POS_BITS'($urandom_range(0, POS_MAX_CODE));
        t.load_value = $urandom();
        t.range_lo   = POS_BITS'($urandom_range(0, POS_MAX_CODE));
        t.range_hi   = POS_BITS'($urandom_range(0, POS_MAX_CODE));
        t.search_key = $urandom();
        return t;
    endfunction

    task automatic plan_cmd(t_search_cmd t);
        pending_cmds.push_back(t);
        if (t.cmd == CMD_LOAD && t.load_pos >= 1 && t.load_pos <= TABLE_DEPTH) begin
            plan_value[t.load_pos] = t.load_value;
            plan_loaded[t.load_pos] = 1'b1;
            n_planned++;
        end else if (t.cmd >= CMD_FIRST_EQ && t.cmd <= CMD_UPPER) begin
            n_planned++;
        end
    endtask

    task automatic plan_load(int pos, logic signed [VALUE_BITS-1:0] v);
        t_search_cmd t;
        t = random_cmd();
        t.cmd = CMD_LOAD;
        t.load_pos = POS_BITS'(pos);
        t.load_value = v;
        plan_cmd(t);
    endtask

    task automatic plan_query(t_cmd c, int lo, int hi, logic signed [VALUE_BITS-1:0] key);
        t_search_cmd t;
        t = random_cmd();
        t.cmd = c;
        t.range_lo = POS_BITS'(lo);
        t.range_hi = POS_BITS'(hi);
        t.search_key = key;
        plan_cmd(t);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] pick_key(int lo, int hi);
        int p;
        p = $urandom_range(lo, hi);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return plan_value[p];
            5:       return plan_value[p] - 1;
            6:       return plan_value[p] + 1;
            7:       return $urandom();
            8:       return VAL_MIN;
            default: return VAL_MAX;
        endcase
    endfunction

    function automatic bit span_loaded(int lo, int hi);
        for (int p = lo; p <= hi; p++) begin
            if (!plan_loaded[p]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic plan_run(int s, int e, bit sorted);
        longint v;
        int     step_max;
        case ($urandom_range(0, 7))
            0:       v = VAL_MIN;
            1:       v = VAL_MAX - $urandom_range(0, 20);
            default: v = $signed($urandom());
        endcase
        step_max = ($urandom_range(0, 3) == 0) ? 1000000 : 2;
        for (int p = s; p <= e; p++) begin
            if (!sorted) v = $signed($urandom());
            plan_load(p, v[VALUE_BITS-1:0]);
            v += $urandom_range(0, step_max);
            if (v > VAL_MAX) v = VAL_MAX;
        end
    endtask

    task automatic plan_span_query(int s, int e);
        int lo;
        int hi;
        if ($urandom_range(0, 5) == 0) begin
            lo = s;
            hi = e;
        end else begin
            lo = $urandom_range(s, e);
            hi = $urandom_range(lo, e);
        end
        plan_query(t_cmd'($urandom_range(CMD_FIRST_EQ, CMD_UPPER)), lo, hi, pick_key(lo, hi));
    endtask

    task automatic plan_random_part();
        t_search_cmd t;
        int len;
        int s;
        int e;
        int lo;
        int hi;
        while (n_planned < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0) begin
                t = random_cmd();
                case ($urandom_range(0, 3))
                    0: t.cmd = CMD_BITS'($urandom_range(CMD_UPPER + 1, CMD_CODES - 1));
                    1: begin
                        t.cmd = CMD_LOAD;
                        t.load_pos = $urandom_range(0, 1) ? '0
                                   : POS_BITS'($urandom_range(TABLE_DEPTH + 1, POS_MAX_CODE));
                    end
                    2: begin
                        t.cmd = CMD_BITS'($urandom_range(CMD_FIRST_EQ, CMD_UPPER));
                        if ($urandom_range(0, 1)) t.range_lo = '0;
                        else t.range_hi = POS_BITS'($urandom_range(TABLE_DEPTH + 1,
                                                                   POS_MAX_CODE));
                    end
                    default: begin
                        t.cmd = CMD_BITS'($urandom_range(CMD_FIRST_EQ, CMD_UPPER));
                        t.range_hi = POS_BITS'($urandom_range(1, TABLE_DEPTH - 1));
                        t.range_lo = POS_BITS'($urandom_range(t.range_hi + 1, POS_MAX_CODE));
                    end
                endcase
                plan_cmd(t);
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 256)
                                                  : $urandom_range(1, 16);
                if ($urandom_range(0, 7) == 0)
                    s = $urandom_range(0, 1) ? 1 : TABLE_DEPTH - len + 1;
                else
                    s = $urandom_range(1, TABLE_DEPTH);
                e = s + len - 1;
                if (e > TABLE_DEPTH) e = TABLE_DEPTH;
                plan_run(s, e, $urandom_range(0, 7) != 0);
                repeat ($urandom_range(1, 8)) begin
                    lo = $urandom_range(1, TABLE_DEPTH);
                    hi = lo + $urandom_range(0, TABLE_DEPTH - 1);
                    if (hi > TABLE_DEPTH) hi = TABLE_DEPTH;
                    if ($urandom_range(0, 3) == 0 && span_loaded(lo, hi))
                        plan_query(t_cmd'($urandom_range(CMD_FIRST_EQ, CMD_UPPER)),
                                   lo, hi, pick_key(lo, hi));
                    else
                        plan_span_query(s, e);
                end
            end
        end
    endtask

    initial begin
        t_search_cmd t;
        plan_load(1, VAL_MIN);
        plan_load(2, VAL_MIN);
        plan_load(3, 0);
        plan_load(4, 5);
        plan_load(5, 5);
        plan_load(TABLE_DEPTH - 1, VAL_MAX);
        plan_load(TABLE_DEPTH, VAL_MAX);
        t = random_cmd();
        t.cmd = CMD_LOAD;
        t.load_pos = '0;
        plan_cmd(t);
        t.load_pos = POS_BITS'(POS_MAX_CODE);
        plan_cmd(t);
        for (int c = CMD_UPPER + 1; c < CMD_CODES; c++) begin
            t = random_cmd();
            t.cmd = CMD_BITS'(c);
            plan_cmd(t);
        end
        plan_query(CMD_FIRST_EQ, 1, 5, VAL_MIN);
        plan_query(CMD_LAST_EQ, 1, 5, VAL_MIN);
        plan_query(CMD_LOWER, 1, 5, 1);
        plan_query(CMD_UPPER, 1, 5, 5);
        plan_query(CMD_UPPER, 1, 5, VAL_MIN);
        plan_query(CMD_FIRST_EQ, 1, 5, 4);
        plan_query(CMD_LOWER, TABLE_DEPTH - 1, TABLE_DEPTH, VAL_MAX);
        plan_query(CMD_LAST_EQ, TABLE_DEPTH - 1, TABLE_DEPTH, VAL_MAX);
        plan_query(CMD_UPPER, TABLE_DEPTH, TABLE_DEPTH, 0);
        plan_query(CMD_LOWER, 0, 5, 0);
        plan_query(CMD_FIRST_EQ, 1, TABLE_DEPTH + 1, 0);
        plan_query(CMD_LAST_EQ, 5, 1, 0);
        plan_query(CMD_UPPER, POS_MAX_CODE, POS_MAX_CODE, 0);
        plan_random_part();
        n_total = pending_cmds.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d loads and %0d/%0d/%0d/%0d first-eq/last-eq/lower/upper queries,",
                 n_loads, n_query[CMD_FIRST_EQ], n_query[CMD_LAST_EQ],
                 n_query[CMD_LOWER], n_query[CMD_UPPER]);
        $display("plus %0d dropped commands; %0d answers checked, %0d found, %0d errors.",
                 n_dropped, n_results, n_hits, n_errors);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_transaction(in_flight);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    in_flight = pending_cmds.pop_front();
                    tx_word = '0;
                    tx_word[CMD_LSB  +: CMD_BITS]   = in_flight.cmd;
                    tx_word[LPOS_LSB +: POS_BITS]   = in_flight.load_pos;
                    tx_word[LVAL_LSB +: VALUE_BITS] = in_flight.load_value;
                    tx_word[LO_LSB   +: POS_BITS]   = in_flight.range_lo;
                    tx_word[HI_LSB   +: POS_BITS]   = in_flight.range_hi;
                    tx_word[KEY_LSB  +: VALUE_BITS] = in_flight.search_key;
                    s_axis_tdata  <= tx_word;
                    s_axis_tvalid <= 1'b1;
                    send_gap = tx_burst ? 0 : $urandom_range(0, 8);
                    if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.found = m_axis_tdata[0];
                got.position = m_axis_tdata[POS_BITS:1];
                n_results++;
                if (got.found) n_hits++;
                if (answers_due.size() == 0) begin
                    $error("unexpected answer transaction: found %0d position %0d",
                           got.found, got.position);
                    n_errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (got.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, got.found);
                        n_errors++;
                    end
                    if (got.position !== want.position) begin
                        $error("position: expected %0d, actual %0d",
                               want.position, got.position);
                        n_errors++;
                    end
                end
                recv_stall = rx_burst ? 0 : $urandom_range(0, 8);
                if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            m_axis_tready <= (recv_stall == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out with %0d of %0d commands sent and %0d answers outstanding.",
                     n_accepted, n_total, answers_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
